// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the camera basis RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define CB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define CB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== rtl/cbasis_pkg.sv =====
// Types, constants and constant functions for the camera basis pipeline.
package cbasis_pkg;

    localparam int VEC_FRAC_BITS = 14;
    localparam int OUT_W         = 16;

    // Angle reduction, 1/64 degree units
    localparam int FULL_TURN    = 23040;
    localparam int HALF_TURN    = 11520;
    localparam int QUARTER_TURN = 5760;
    localparam int ANG_SHIFT    = 14;

    // CORDIC datapath
    localparam int CORDIC_W = 33;
    localparam int ZW       = 29;
    localparam int ATAN_W   = 26;
    localparam longint CORDIC_GAIN_Q30 = 652032874;

    // Normalizer datapath
    localparam int MAG_W      = 31;
    localparam int SQ_W       = 64;
    localparam int SQRT_STEPS = 32;
    localparam int LEN_W      = 32;
    localparam int QUO_W      = VEC_FRAC_BITS + 1;
    localparam int REM_W      = LEN_W + QUO_W;

    // Cross product datapath
    localparam int PRD_W   = 32;
    localparam int CROSS_W = 33;

    typedef enum logic [1:0] {
        CFG_WORLD_UP_X = 2'd0,
        CFG_WORLD_UP_Y = 2'd1,
        CFG_WORLD_UP_Z = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [ZW-1:0]       z;
    } t_lane;

    // atan(2^-k) in units of 2^-20 degree
    function automatic logic [ATAN_W-1:0] atan_deg20(input logic [4:0] k);
        logic [ATAN_W-1:0] a;
        case (k)
            5'd0:  a = 26'd47185920;
            5'd1:  a = 26'd27855475;
            5'd2:  a = 26'd14718068;
            5'd3:  a = 26'd7471121;
            5'd4:  a = 26'd3750058;
            5'd5:  a = 26'd1876857;
            5'd6:  a = 26'd938658;
            5'd7:  a = 26'd469358;
            5'd8:  a = 26'd234682;
            5'd9:  a = 26'd117342;
            5'd10: a = 26'd58671;
            5'd11: a = 26'd29335;
            5'd12: a = 26'd14668;
            5'd13: a = 26'd7334;
            5'd14: a = 26'd3667;
            5'd15: a = 26'd1833;
            5'd16: a = 26'd917;
            5'd17: a = 26'd458;
            5'd18: a = 26'd229;
            5'd19: a = 26'd115;
            5'd20: a = 26'd57;
            5'd21: a = 26'd29;
            5'd22: a = 26'd14;
            5'd23: a = 26'd7;
            5'd24: a = 26'd4;
            5'd25: a = 26'd2;
            5'd26: a = 26'd1;
            default: a = 26'd0;
        endcase
        return a;
    endfunction

    // Cosine output of the CORDIC at angle zero; used at elaboration only
    function automatic logic signed [CORDIC_W-1:0] cordic_unit(input int steps);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = CORDIC_GAIN_Q30;
        y = 0;
        z = 0;
        for (int i = 0; i < steps; i++) begin
            dx = y >>> (i % 32);
            dy = x >>> (i % 32);
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(atan_deg20(5'(i % 32)));
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(atan_deg20(5'(i % 32)));
            end
        end
        return CORDIC_W'(x);
    endfunction

endpackage

// ===== rtl/cbasis_cordic_cell.sv =====
// One CORDIC rotation step for the yaw and pitch lanes.
module cbasis_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_vld,
    input  cbasis_pkg::t_lane [1:0] i_lane,
    input  logic [1:0]              i_flip,
    output logic                    o_vld,
    output cbasis_pkg::t_lane [1:0] o_lane,
    output logic [1:0]              o_flip
);
    import cbasis_pkg::*;

    localparam int SH = STEP % 32;
    localparam logic signed [ZW-1:0] ATAN = ZW'(atan_deg20(5'(SH)));

    logic            r_vld;
    t_lane [1:0]     r_lane;
    t_lane [1:0]     n_lane;
    logic [1:0]      r_flip;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (i_lane[l].z >= 0) begin
                n_lane[l].x = i_lane[l].x - (i_lane[l].y >>> SH);
                n_lane[l].y = i_lane[l].y + (i_lane[l].x >>> SH);
                n_lane[l].z = i_lane[l].z - ATAN;
            end else begin
                n_lane[l].x = i_lane[l].x + (i_lane[l].y >>> SH);
                n_lane[l].y = i_lane[l].y - (i_lane[l].x >>> SH);
                n_lane[l].z = i_lane[l].z + ATAN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
            r_flip <= i_flip;
        end
    end

    assign o_vld  = r_vld;
    assign o_lane = r_lane;
    assign o_flip = r_flip;

endmodule

// ===== rtl/cbasis_sqrt_cell.sv =====
// One digit step of the integer square root.
module cbasis_sqrt_cell #(
    parameter int STEP = 0,
    parameter int TW   = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [cbasis_pkg::SQ_W-1:0] i_n,
    input  logic [cbasis_pkg::SQ_W-1:0] i_r,
    input  logic [TW-1:0]               i_tag,
    output logic                        o_vld,
    output logic [cbasis_pkg::SQ_W-1:0] o_n,
    output logic [cbasis_pkg::SQ_W-1:0] o_r,
    output logic [TW-1:0]               o_tag
);
    import cbasis_pkg::*;

    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * STEP);

    logic            r_vld;
    logic [SQ_W-1:0] r_n;
    logic [SQ_W-1:0] r_r;
    logic [TW-1:0]   r_tag;
    logic [SQ_W-1:0] w_trial;
    logic [SQ_W-1:0] n_n;
    logic [SQ_W-1:0] n_r;

    always_comb begin
        w_trial = i_r + BIT;
        if (i_n >= w_trial) begin
            n_n = i_n - w_trial;
            n_r = (i_r >> 1) + BIT;
        end else begin
            n_n = i_n;
            n_r = i_r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n   <= n_n;
            r_r   <= n_r;
            r_tag <= i_tag;
        end
    end

    assign o_vld = r_vld;
    assign o_n   = r_n;
    assign o_r   = r_r;
    assign o_tag = r_tag;

endmodule

// ===== rtl/cbasis_div_cell.sv =====
// One quotient bit of the restoring divider, three components at once.
module cbasis_div_cell #(
    parameter int BIT_POS = 0,
    parameter int TW      = 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_vld,
    input  logic [2:0][cbasis_pkg::REM_W-1:0] i_rem,
    input  logic [cbasis_pkg::LEN_W-1:0]      i_den,
    input  logic [2:0][cbasis_pkg::QUO_W-1:0] i_q,
    input  logic [TW-1:0]                     i_tag,
    output logic                              o_vld,
    output logic [2:0][cbasis_pkg::REM_W-1:0] o_rem,
    output logic [cbasis_pkg::LEN_W-1:0]      o_den,
    output logic [2:0][cbasis_pkg::QUO_W-1:0] o_q,
    output logic [TW-1:0]                     o_tag
);
    import cbasis_pkg::*;

    logic                   r_vld;
    logic [2:0][REM_W-1:0]  r_rem;
    logic [LEN_W-1:0]       r_den;
    logic [2:0][QUO_W-1:0]  r_q;
    logic [TW-1:0]          r_tag;
    logic [2:0][REM_W-1:0]  n_rem;
    logic [2:0][QUO_W-1:0]  n_q;
    logic [REM_W-1:0]       w_dsh;

    always_comb begin
        w_dsh = REM_W'(i_den) << BIT_POS;
        for (int k = 0; k < 3; k++) begin
            if (i_rem[k] >= w_dsh) begin
                n_rem[k] = i_rem[k] - w_dsh;
                n_q[k]   = i_q[k] | (QUO_W'(1) << BIT_POS);
            end else begin
                n_rem[k] = i_rem[k];
                n_q[k]   = i_q[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_den <= i_den;
            r_q   <= n_q;
            r_tag <= i_tag;
        end
    end

    assign o_vld = r_vld;
    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_q   = r_q;
    assign o_tag = r_tag;

endmodule

// ===== rtl/cbasis_norm.sv =====
// Pipelined 3-vector normalizer: scale down, sum of squares, root, divide.
module cbasis_norm #(
    parameter int IW  = 33,
    parameter int SBW = 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_vld,
    input  logic [2:0][IW-1:0]                i_v,
    input  logic [SBW-1:0]                    i_sb,
    output logic                              o_vld,
    output logic [2:0][cbasis_pkg::OUT_W-1:0] o_v,
    output logic [SBW-1:0]                    o_sb
);
    import cbasis_pkg::*;

    localparam int SHW = $clog2(IW);
    localparam int TW  = 3 * MAG_W + 3 + SBW;
    localparam int DTW = SBW + 4;

    // stage A: magnitudes
    logic                   r_a_vld;
    logic [2:0][IW-1:0]     r_a_m;
    logic [2:0][IW-1:0]     n_a_m;
    logic [2:0]             r_a_ng;
    logic [SBW-1:0]         r_a_sb;
    // stage B: shift count
    logic [IW-1:0]          w_mx;
    logic [SHW-1:0]         n_b_sh;
    logic                   r_b_vld;
    logic [2:0][IW-1:0]     r_b_m;
    logic [SHW-1:0]         r_b_sh;
    logic [2:0]             r_b_ng;
    logic [SBW-1:0]         r_b_sb;
    // stage C: scaled magnitudes
    logic [2:0][MAG_W-1:0]  n_c_m;
    logic                   r_c_vld;
    logic [2:0][MAG_W-1:0]  r_c_m;
    logic [2:0]             r_c_ng;
    logic [SBW-1:0]         r_c_sb;
    // stage D: squares
    logic [2:0][2*MAG_W-1:0] n_d_sq;
    logic                   r_d_vld;
    logic [2:0][2*MAG_W-1:0] r_d_sq;
    logic [2:0][MAG_W-1:0]  r_d_m;
    logic [2:0]             r_d_ng;
    logic [SBW-1:0]         r_d_sb;
    // stage E: sum
    logic [SQ_W-1:0]        n_e_sum;
    logic                   r_e_vld;
    logic [SQ_W-1:0]        r_e_sum;
    logic [2:0][MAG_W-1:0]  r_e_m;
    logic [2:0]             r_e_ng;
    logic [SBW-1:0]         r_e_sb;
    // root chain
    logic                   w_s_vld [SQRT_STEPS+1];
    logic [SQ_W-1:0]        w_s_n   [SQRT_STEPS+1];
    logic [SQ_W-1:0]        w_s_r   [SQRT_STEPS+1];
    logic [TW-1:0]          w_s_tag [SQRT_STEPS+1];
    // stage F: dividend set-up
    logic [LEN_W-1:0]       w_len;
    logic [2:0][MAG_W-1:0]  w_f_m;
    logic [2:0][REM_W-1:0]  n_f_rem;
    logic                   r_f_vld;
    logic [2:0][REM_W-1:0]  r_f_rem;
    logic [LEN_W-1:0]       r_f_den;
    logic [DTW-1:0]         r_f_tag;
    // divide chain
    logic                   w_d_vld [QUO_W+1];
    logic [2:0][REM_W-1:0]  w_d_rem [QUO_W+1];
    logic [LEN_W-1:0]       w_d_den [QUO_W+1];
    logic [2:0][QUO_W-1:0]  w_d_q   [QUO_W+1];
    logic [DTW-1:0]         w_d_tag [QUO_W+1];
    // stage G: signs
    logic [2:0][OUT_W-1:0]  n_g_v;
    logic [DTW-1:0]         w_g_tag;
    logic                   r_g_vld;
    logic [2:0][OUT_W-1:0]  r_g_v;
    logic [SBW-1:0]         r_g_sb;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_a_m[k] = i_v[k][IW-1] ? (~i_v[k] + IW'(1)) : i_v[k];
        end
    end

    // smallest right shift that brings all magnitudes below 2^MAG_W
    always_comb begin
        w_mx   = r_a_m[0] | r_a_m[1] | r_a_m[2];
        n_b_sh = '0;
        for (int i = MAG_W; i < IW; i++) begin
            if (w_mx[i]) begin
                n_b_sh = SHW'(i - MAG_W + 1);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_c_m[k]  = MAG_W'(r_b_m[k] >> r_b_sh);
            n_d_sq[k] = r_c_m[k] * r_c_m[k];
        end
        n_e_sum = SQ_W'(r_d_sq[0]) + SQ_W'(r_d_sq[1]) + SQ_W'(r_d_sq[2]);
    end

    assign w_s_vld[0] = r_e_vld;
    assign w_s_n[0]   = r_e_sum;
    assign w_s_r[0]   = '0;
    assign w_s_tag[0] = {r_e_sb, r_e_ng, r_e_m};

    for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_sqrt
        cbasis_sqrt_cell #(
            .STEP (s),
            .TW   (TW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_vld   (w_s_vld[s]),
            .i_n     (w_s_n[s]),
            .i_r     (w_s_r[s]),
            .i_tag   (w_s_tag[s]),
            .o_vld   (w_s_vld[s+1]),
            .o_n     (w_s_n[s+1]),
            .o_r     (w_s_r[s+1]),
            .o_tag   (w_s_tag[s+1])
        );
    end

    // dividend = m * 2^frac + len/2, so the quotient rounds half up
    always_comb begin
        w_len = w_s_r[SQRT_STEPS][LEN_W-1:0];
        for (int k = 0; k < 3; k++) begin
            w_f_m[k]   = w_s_tag[SQRT_STEPS][k*MAG_W +: MAG_W];
            n_f_rem[k] = (REM_W'(w_f_m[k]) << VEC_FRAC_BITS) + REM_W'(w_len >> 1);
        end
    end

    assign w_d_vld[0] = r_f_vld;
    assign w_d_rem[0] = r_f_rem;
    assign w_d_den[0] = r_f_den;
    assign w_d_q[0]   = '0;
    assign w_d_tag[0] = r_f_tag;

    for (genvar j = 0; j < QUO_W; j++) begin : g_div
        cbasis_div_cell #(
            .BIT_POS (QUO_W - 1 - j),
            .TW      (DTW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_vld   (w_d_vld[j]),
            .i_rem   (w_d_rem[j]),
            .i_den   (w_d_den[j]),
            .i_q     (w_d_q[j]),
            .i_tag   (w_d_tag[j]),
            .o_vld   (w_d_vld[j+1]),
            .o_rem   (w_d_rem[j+1]),
            .o_den   (w_d_den[j+1]),
            .o_q     (w_d_q[j+1]),
            .o_tag   (w_d_tag[j+1])
        );
    end

    // zero length gives a zero vector
    always_comb begin
        w_g_tag = w_d_tag[QUO_W];
        for (int k = 0; k < 3; k++) begin
            if (w_g_tag[3]) begin
                n_g_v[k] = '0;
            end else if (w_g_tag[k]) begin
                n_g_v[k] = -OUT_W'(w_d_q[QUO_W][k]);
            end else begin
                n_g_v[k] = OUT_W'(w_d_q[QUO_W][k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
            r_f_vld <= w_s_vld[SQRT_STEPS];
            r_g_vld <= w_d_vld[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_m   <= n_a_m;
            r_a_ng  <= {i_v[2][IW-1], i_v[1][IW-1], i_v[0][IW-1]};
            r_a_sb  <= i_sb;
            r_b_m   <= r_a_m;
            r_b_sh  <= n_b_sh;
            r_b_ng  <= r_a_ng;
            r_b_sb  <= r_a_sb;
            r_c_m   <= n_c_m;
            r_c_ng  <= r_b_ng;
            r_c_sb  <= r_b_sb;
            r_d_sq  <= n_d_sq;
            r_d_m   <= r_c_m;
            r_d_ng  <= r_c_ng;
            r_d_sb  <= r_c_sb;
            r_e_sum <= n_e_sum;
            r_e_m   <= r_d_m;
            r_e_ng  <= r_d_ng;
            r_e_sb  <= r_d_sb;
            r_f_rem <= n_f_rem;
            r_f_den <= w_len;
            r_f_tag <= {w_s_tag[SQRT_STEPS][TW-1 -: SBW], (w_len == '0),
                        w_s_tag[SQRT_STEPS][3*MAG_W +: 3]};
            r_g_v   <= n_g_v;
            r_g_sb  <= w_g_tag[DTW-1 -: SBW];
        end
    end

    assign o_vld = r_g_vld;
    assign o_v   = r_g_v;
    assign o_sb  = r_g_sb;

endmodule

// ===== rtl/camera_basis_from_yaw_pitch.sv =====
// Top level: camera front and up vectors from yaw and pitch.
//
// Takes one (yaw, pitch) beat per clock, angles in 1/64 degree, and returns
// the unit front vector and the unit camera up vector in Q1.14, plus a flag
// that is set when front is parallel to the configured world up and the
// (0,0,-1) fallback axis was used for the right vector. Angles wrap modulo
// 360 degrees. Sine and cosine come from a chain of CORDIC_STEPS rotation
// cells; each of the three normalizations (front, right, up) is a 54-stage
// pipe of its own: magnitude scaling, squares, a 32-cell square root chain
// and a 15-cell restoring divider. Throughput is one beat per cycle while
// the pipe is not held. The whole pipe holds only when the result register
// is full, not taken, and the last stage carries a beat, so bubbles still
// drain while a result waits. The user must write world up through the plain
// write port only while the block is idle; the block itself does not enforce
// this. Reset value is (0, 1.0, 0). Indexes 0..2 select x, y, z.
module camera_basis_from_yaw_pitch #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_yaw_angle,
    input  logic signed [15:0] i_pitch_angle,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_front_x,
    output logic signed [15:0] o_front_y,
    output logic signed [15:0] o_front_z,
    output logic signed [15:0] o_up_x,
    output logic signed [15:0] o_up_y,
    output logic signed [15:0] o_up_z,
    output logic               o_fallback_used
);
    import cbasis_pkg::*;

    `include "assert_macros.svh"

    localparam logic signed [CORDIC_W-1:0] UNIT = cordic_unit(CORDIC_STEPS);
    localparam int PW  = 2 * CORDIC_W;
    localparam int VW  = 3 * OUT_W;

    // Reduce an angle to [-90,90] degrees; returns {flip, z in 2^-20 degree}.
    function automatic logic [ZW:0] fold_angle(input logic signed [15:0] a);
        logic signed [17:0] t;
        logic [16:0]        v;
        logic [16:0]        r;
        logic signed [15:0] s;
        logic               flip;
        t = {{2{a[15]}}, a} + 18'(2 * FULL_TURN);
        v = t[16:0];
        if (v >= 17'(3 * FULL_TURN)) begin
            r = v - 17'(3 * FULL_TURN);
        end else if (v >= 17'(2 * FULL_TURN)) begin
            r = v - 17'(2 * FULL_TURN);
        end else if (v >= 17'(FULL_TURN)) begin
            r = v - 17'(FULL_TURN);
        end else begin
            r = v;
        end
        s = (r >= 17'(HALF_TURN)) ? 16'(r) - 16'(FULL_TURN) : 16'(r);
        flip = 1'b0;
        if (s > 16'sd5760) begin
            s    = 16'(HALF_TURN) - s;
            flip = 1'b1;
        end else if (s < -16'sd5760) begin
            s    = -16'(HALF_TURN) - s;
            flip = 1'b1;
        end
        return {flip, ZW'(s) <<< ANG_SHIFT};
    endfunction

    // Squared length of a cross product below 8 units, i.e. all parts tiny
    function automatic logic is_tiny(input logic [2:0][CROSS_W-1:0] v);
        logic [3:0] sum;
        logic       all_low;
        logic signed [CROSS_W-1:0] c;
        sum     = '0;
        all_low = 1'b1;
        for (int k = 0; k < 3; k++) begin
            c = $signed(v[k]);
            if (c > 2 || c < -2) begin
                all_low = 1'b0;
            end else if (c == 2 || c == -2) begin
                sum = sum + 4'd4;
            end else if (c != 0) begin
                sum = sum + 4'd1;
            end
        end
        return all_low && (sum < 4'd8);
    endfunction

    // ---- configuration ----
    logic signed [15:0] r_wu_x;
    logic signed [15:0] r_wu_y;
    logic signed [15:0] r_wu_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wu_x <= 16'sd0;
            r_wu_y <= 16'sd16384;
            r_wu_z <= 16'sd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WORLD_UP_X: r_wu_x <= i_cfg_data;
                CFG_WORLD_UP_Y: r_wu_y <= i_cfg_data;
                CFG_WORLD_UP_Z: r_wu_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---- pipeline advance ----
    logic w_en;
    logic w_last_vld;

    // hold everything only when the result waits and the last stage is full
    assign w_en       = !(o_out_valid && !i_out_ready && w_last_vld);
    assign o_in_ready = w_en;

    // ---- stage 0: angle reduction ----
    logic [ZW:0]  w_fy;
    logic [ZW:0]  w_fp;
    t_lane [1:0]  n_s0_lane;
    logic         r_s0_vld;
    t_lane [1:0]  r_s0_lane;
    logic [1:0]   r_s0_flip;
    logic [VW-1:0] r_s0_wu;

    always_comb begin
        w_fy = fold_angle(i_yaw_angle);
        w_fp = fold_angle(i_pitch_angle);
        n_s0_lane[0].x = CORDIC_W'(CORDIC_GAIN_Q30);
        n_s0_lane[0].y = '0;
        n_s0_lane[0].z = w_fy[ZW-1:0];
        n_s0_lane[1].x = CORDIC_W'(CORDIC_GAIN_Q30);
        n_s0_lane[1].y = '0;
        n_s0_lane[1].z = w_fp[ZW-1:0];
    end

    // ---- CORDIC chain: lane 0 is yaw, lane 1 is pitch ----
    logic        w_c_vld  [CORDIC_STEPS+1];
    t_lane [1:0] w_c_lane [CORDIC_STEPS+1];
    logic [1:0]  w_c_flip [CORDIC_STEPS+1];
    logic [VW-1:0] r_wu_pipe [CORDIC_STEPS];

    assign w_c_vld[0]  = r_s0_vld;
    assign w_c_lane[0] = r_s0_lane;
    assign w_c_flip[0] = r_s0_flip;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        cbasis_cordic_cell #(
            .STEP (i)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_c_vld[i]),
            .i_lane  (w_c_lane[i]),
            .i_flip  (w_c_flip[i]),
            .o_vld   (w_c_vld[i+1]),
            .o_lane  (w_c_lane[i+1]),
            .o_flip  (w_c_flip[i+1])
        );
        // world up snapshot travels with the beat
        if (i == 0) begin : g_wu0
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_wu_pipe[i] <= r_s0_wu;
                end
            end
        end else begin : g_wun
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_wu_pipe[i] <= r_wu_pipe[i-1];
                end
            end
        end
    end

    // ---- product stage: raw front vector ----
    logic signed [CORDIC_W-1:0] w_cp;
    logic signed [CORDIC_W-1:0] w_ncy;
    logic signed [PW-1:0]       n_p0;
    logic signed [PW-1:0]       n_p1;
    logic signed [PW-1:0]       n_p2;
    logic                       r_m_vld;
    logic [2:0][PW-1:0]         r_m_f;
    logic [VW-1:0]              r_m_wu;

    always_comb begin
        w_cp  = w_c_flip[CORDIC_STEPS][1] ? -w_c_lane[CORDIC_STEPS][1].x
                                          :  w_c_lane[CORDIC_STEPS][1].x;
        // negated yaw cosine gives the minus sign of front z directly
        w_ncy = w_c_flip[CORDIC_STEPS][0] ?  w_c_lane[CORDIC_STEPS][0].x
                                          : -w_c_lane[CORDIC_STEPS][0].x;
        n_p0  = w_c_lane[CORDIC_STEPS][0].y * w_cp;
        n_p1  = w_c_lane[CORDIC_STEPS][1].y * UNIT;
        n_p2  = w_ncy * w_cp;
    end

    // ---- normalize front ----
    logic                  w_n1_vld;
    logic [2:0][OUT_W-1:0] w_n1_v;
    logic [VW-1:0]         w_n1_sb;

    cbasis_norm #(
        .IW  (PW),
        .SBW (VW)
    ) u_norm_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_m_vld),
        .i_v     (r_m_f),
        .i_sb    (r_m_wu),
        .o_vld   (w_n1_vld),
        .o_v     (w_n1_v),
        .o_sb    (w_n1_sb)
    );

    // ---- right = front x world_up, products then differences ----
    logic signed [OUT_W-1:0] w_fr [3];
    logic signed [OUT_W-1:0] w_wu [3];
    logic                    r_x1_vld;
    logic signed [PRD_W-1:0] r_x1_p [6];
    logic [VW-1:0]           r_x1_fr;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_fr[k] = $signed(w_n1_v[k]);
            w_wu[k] = $signed(w_n1_sb[k*OUT_W +: OUT_W]);
        end
    end

    logic [2:0][CROSS_W-1:0] n_x2_rr;
    logic [2:0][CROSS_W-1:0] w_x2_cr;
    logic signed [OUT_W-1:0] w_x2_fr [3];
    logic                    n_x2_fb;
    logic                    r_x2_vld;
    logic [2:0][CROSS_W-1:0] r_x2_rr;
    logic [VW-1:0]           r_x2_fr;
    logic                    r_x2_fb;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_x2_fr[k] = $signed(r_x1_fr[k*OUT_W +: OUT_W]);
            w_x2_cr[k] = CROSS_W'(r_x1_p[2*k]) - CROSS_W'(r_x1_p[2*k+1]);
        end
        n_x2_fb = is_tiny(w_x2_cr);
        if (n_x2_fb) begin
            // front x (0,0,-1)
            n_x2_rr[0] = -CROSS_W'(w_x2_fr[1]);
            n_x2_rr[1] =  CROSS_W'(w_x2_fr[0]);
            n_x2_rr[2] = '0;
        end else begin
            n_x2_rr = w_x2_cr;
        end
    end

    // ---- normalize right ----
    logic                  w_n2_vld;
    logic [2:0][OUT_W-1:0] w_n2_v;
    logic [VW:0]           w_n2_sb;

    cbasis_norm #(
        .IW  (CROSS_W),
        .SBW (VW + 1)
    ) u_norm_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_x2_vld),
        .i_v     (r_x2_rr),
        .i_sb    ({r_x2_fb, r_x2_fr}),
        .o_vld   (w_n2_vld),
        .o_v     (w_n2_v),
        .o_sb    (w_n2_sb)
    );

    // ---- up = right x front ----
    logic signed [OUT_W-1:0] w_rn [3];
    logic signed [OUT_W-1:0] w_f2 [3];
    logic                    r_x3_vld;
    logic signed [PRD_W-1:0] r_x3_p [6];
    logic [VW:0]             r_x3_sb;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_rn[k] = $signed(w_n2_v[k]);
            w_f2[k] = $signed(w_n2_sb[k*OUT_W +: OUT_W]);
        end
    end

    logic [2:0][CROSS_W-1:0] n_x4_uu;
    logic                    r_x4_vld;
    logic [2:0][CROSS_W-1:0] r_x4_uu;
    logic [VW:0]             r_x4_sb;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_x4_uu[k] = CROSS_W'(r_x3_p[2*k]) - CROSS_W'(r_x3_p[2*k+1]);
        end
    end

    // ---- normalize up ----
    logic [2:0][OUT_W-1:0] w_n3_v;
    logic [VW:0]           w_n3_sb;

    cbasis_norm #(
        .IW  (CROSS_W),
        .SBW (VW + 1)
    ) u_norm_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_x4_vld),
        .i_v     (r_x4_uu),
        .i_sb    (r_x4_sb),
        .o_vld   (w_last_vld),
        .o_v     (w_n3_v),
        .o_sb    (w_n3_sb)
    );

    // ---- control registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld    <= 1'b0;
            r_m_vld     <= 1'b0;
            r_x1_vld    <= 1'b0;
            r_x2_vld    <= 1'b0;
            r_x3_vld    <= 1'b0;
            r_x4_vld    <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (w_en) begin
                r_s0_vld <= i_in_valid;
                r_m_vld  <= w_c_vld[CORDIC_STEPS];
                r_x1_vld <= w_n1_vld;
                r_x2_vld <= r_x1_vld;
                r_x3_vld <= w_n2_vld;
                r_x4_vld <= r_x3_vld;
            end
            // load a finished beat, or drop the one taken downstream
            if (w_en && w_last_vld) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // ---- payload registers ----
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_lane <= n_s0_lane;
            r_s0_flip <= {w_fp[ZW], w_fy[ZW]};
            r_s0_wu   <= {r_wu_z, r_wu_y, r_wu_x};
            r_m_f     <= {n_p2, n_p1, n_p0};
            r_m_wu    <= r_wu_pipe[CORDIC_STEPS-1];
            r_x1_p[0] <= w_fr[1] * w_wu[2];
            r_x1_p[1] <= w_fr[2] * w_wu[1];
            r_x1_p[2] <= w_fr[2] * w_wu[0];
            r_x1_p[3] <= w_fr[0] * w_wu[2];
            r_x1_p[4] <= w_fr[0] * w_wu[1];
            r_x1_p[5] <= w_fr[1] * w_wu[0];
            r_x1_fr   <= w_n1_v;
            r_x2_rr   <= n_x2_rr;
            r_x2_fr   <= r_x1_fr;
            r_x2_fb   <= n_x2_fb;
            r_x3_p[0] <= w_rn[1] * w_f2[2];
            r_x3_p[1] <= w_rn[2] * w_f2[1];
            r_x3_p[2] <= w_rn[2] * w_f2[0];
            r_x3_p[3] <= w_rn[0] * w_f2[2];
            r_x3_p[4] <= w_rn[0] * w_f2[1];
            r_x3_p[5] <= w_rn[1] * w_f2[0];
            r_x3_sb   <= w_n2_sb;
            r_x4_uu   <= n_x4_uu;
            r_x4_sb   <= r_x3_sb;
        end
        if (w_en && w_last_vld) begin
            o_front_x       <= $signed(w_n3_sb[0*OUT_W +: OUT_W]);
            o_front_y       <= $signed(w_n3_sb[1*OUT_W +: OUT_W]);
            o_front_z       <= $signed(w_n3_sb[2*OUT_W +: OUT_W]);
            o_up_x          <= $signed(w_n3_v[0]);
            o_up_y          <= $signed(w_n3_v[1]);
            o_up_z          <= $signed(w_n3_v[2]);
            o_fallback_used <= w_n3_sb[VW];
        end
    end

    // ---- checks ----
    `CB_ASSERT_IMP(a_stall_only_on_backpressure, !o_in_ready, o_out_valid && !i_out_ready)
    `CB_ASSERT_IMP(a_result_from_last_stage, $rose(o_out_valid), $past(w_last_vld))
    `CB_ASSERT_NXT(a_empty_result_loads, !o_out_valid && w_last_vld, o_out_valid)
    `CB_ASSERT_IMP(a_front_y_unit, o_out_valid, (o_front_y <= 16'sd16384) && (o_front_y >= -16'sd16384))

endmodule
